>>> sv/lru_cache_with_floor_fallback_defines.svh
// Assertion macros shared by the checker of the LRU cache.
`ifndef LRU_CACHE_WITH_FLOOR_FALLBACK_DEFINES_SVH
`define LRU_CACHE_WITH_FLOOR_FALLBACK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LRUC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lruc assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define LRUC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lruc assertion failed");

`endif

>>> sv/lruc_pkg.sv
// Package: widths, entry types and codes of the LRU cache.
package lruc_pkg;

  localparam int LRUC_ENTRIES = 8;
  localparam int LRUC_IDX_W   = $clog2(LRUC_ENTRIES);
  localparam int LRUC_KEY_W   = 8;
  localparam int LRUC_TKEY_W  = 7;
  localparam int LRUC_VAL_W   = 32;
  localparam int LRUC_STAMP_W = 8;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ADD    = 1'b1
  } lruc_op_t;

  // Stored tag: occupied flag (0x80) over the 7-bit key (0x7f).
  typedef struct packed {
    logic                   occ;
    logic [LRUC_TKEY_W-1:0] key;
  } lruc_tag_t;

  typedef struct packed {
    lruc_tag_t               tag;
    logic [LRUC_VAL_W-1:0]   data;
    logic [LRUC_STAMP_W-1:0] stamp;
  } lruc_entry_t;

  // Broadcast write into the ring; fill also rewrites tag and data.
  typedef struct packed {
    logic                    en;
    logic                    fill;
    lruc_tag_t               tag;
    logic [LRUC_VAL_W-1:0]   data;
    logic [LRUC_STAMP_W-1:0] stamp;
  } lruc_wr_t;

endpackage

>>> sv/lruc_in_if.sv
// Request channel: operation, key and write value.
interface lruc_in_if import lruc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [LRUC_KEY_W-1:0] key;
  logic [LRUC_VAL_W-1:0] write_value;

  modport source(output valid, operation, key, write_value, input ready);
  modport sink(input valid, operation, key, write_value, output ready);
endinterface

>>> sv/lruc_out_if.sv
// Response channel: hit, exact and read value.
interface lruc_out_if import lruc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic                  exact;
  logic [LRUC_VAL_W-1:0] read_value;

  modport source(output valid, hit, exact, read_value, input ready);
  modport sink(input valid, hit, exact, read_value, output ready);
endinterface

>>> sv/lru_cache_with_floor_fallback.sv
// Top level: LRU key-to-value cache with floor fallback on lookup.
//
// req (sink) carries one beat per operation: a lookup of a 7-bit key, or an
// add of a key with a 32-bit value. rsp (source) returns exactly one beat per
// request: hit, exact and read_value (all zero for an add or a miss).
// The store is a ring of ENTRIES cells. Each cell holds one entry plus its
// slot number, and the whole ring rotates by one cell per scan cycle, so
// every entry passes the head cell once. The scan keeps the best exact,
// floor and empty candidates, ranked by scan order from the start slot
// ((key-1) mod ENTRIES), and the oldest by stamp. The chosen slot is then
// updated by a broadcast write matched on slot number.
// Each request passes a remainder step (ST_MOD), a scan of the whole ring
// (ST_SCAN) and an update step (ST_DONE); one request is in flight at a
// time, and a new one is taken only after the block is back in idle.
// req.ready is high only when the block is idle. A finished response sits in
// the output register; while rsp is stalled the next request can still be
// accepted and scanned, and it waits for the register before its update.
// Synchronous reset clears the ring (unoccupied, zero stamps), the use clock
// and the response register.
module lru_cache_with_floor_fallback import lruc_pkg::*; #(
  parameter int ENTRIES = LRUC_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  lruc_in_if.sink    req,
  lruc_out_if.source rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  // request
  logic                    op_add;
  logic [LRUC_TKEY_W-1:0]  k_reg;
  logic [LRUC_VAL_W-1:0]   val_reg;
  logic [LRUC_STAMP_W-1:0] use_clock;
  logic [IDX_W-1:0]        scan_base;
  logic [IDX_W-1:0]        cnt;

  // scan candidates
  logic                    exact_found;
  logic [IDX_W-1:0]        exact_id;
  logic [IDX_W-1:0]        exact_rank;
  logic [LRUC_VAL_W-1:0]   exact_data;
  logic [LRUC_TKEY_W-1:0]  best_key;
  logic [IDX_W-1:0]        best_id;
  logic [IDX_W-1:0]        best_rank;
  logic [LRUC_VAL_W-1:0]   best_data;
  logic                    empty_found;
  logic [IDX_W-1:0]        empty_id;
  logic [IDX_W-1:0]        empty_rank;
  logic                    old_found;
  logic [IDX_W-1:0]        old_id;
  logic [LRUC_STAMP_W-1:0] old_stamp;

  // response register
  logic                    out_valid;
  logic                    out_hit;
  logic                    out_exact;
  logic [LRUC_VAL_W-1:0]   out_value;

  // ring
  lruc_entry_t             cell_ent [ENTRIES];
  logic [IDX_W-1:0]        cell_id  [ENTRIES];
  logic                    shift;
  lruc_wr_t                wr;
  logic [IDX_W-1:0]        wr_id;

  // remainder unit
  logic                    mod_start;
  logic                    mod_done;
  logic [IDX_W-1:0]        mod_rem;

  // head of the ring
  lruc_entry_t             head;
  logic [IDX_W-1:0]        head_id;
  logic [IDX_W:0]          rank_wide;
  logic [IDX_W-1:0]        head_rank;
  logic                    take_exact;
  logic                    take_floor;
  logic                    take_empty;
  logic                    take_old;
  logic                    out_free;
  logic                    finish;

  assign req.ready  = (state == ST_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.hit    = out_hit;
  assign rsp.exact  = out_exact;
  assign rsp.read_value = out_value;

  assign mod_start = req.valid && req.ready;
  assign shift     = (state == ST_SCAN);
  assign out_free  = !out_valid || rsp.ready;
  assign finish    = (state == ST_DONE) && out_free;

  lruc_mod_unit #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.key - LRUC_KEY_W'(1)),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    localparam int NB = (g + 1) % ENTRIES;
    lruc_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .home_id (IDX_W'(g)),
      .shift   (shift),
      .nbr_ent (cell_ent[NB]),
      .nbr_id  (cell_id[NB]),
      .wr      (wr),
      .wr_id   (wr_id),
      .ent     (cell_ent[g]),
      .id      (cell_id[g])
    );
  end

  // Scan order rank of the head slot relative to the start slot.
  always_comb begin
    head    = cell_ent[0];
    head_id = cell_id[0];
    if (head_id >= scan_base) begin
      rank_wide = {1'b0, head_id} - {1'b0, scan_base};
    end else begin
      rank_wide = {1'b0, head_id} + (IDX_W+1)'(ENTRIES) - {1'b0, scan_base};
    end
    head_rank = rank_wide[IDX_W-1:0];

    take_exact = head.tag.occ && (head.tag.key == k_reg) &&
                 (!exact_found || (head_rank < exact_rank));
    // floor: greatest key below the request and above zero, first in scan order
    take_floor = head.tag.occ && (head.tag.key < k_reg) &&
                 ((head.tag.key > best_key) ||
                  ((head.tag.key == best_key) && (best_key != '0) &&
                   (head_rank < best_rank)));
    take_empty = !head.tag.occ && (!empty_found || (head_rank < empty_rank));
    // oldest: lowest stamp below the clock, lowest slot on a tie
    take_old   = (head.stamp < use_clock) &&
                 (!old_found || (head.stamp < old_stamp) ||
                  ((head.stamp == old_stamp) && (head_id < old_id)));
  end

  // Update of the chosen slot, applied in the cycle the response is loaded.
  always_comb begin
    wr       = '0;
    wr.stamp = use_clock;
    wr.tag   = '{occ: 1'b1, key: k_reg};
    wr.data  = val_reg;
    wr_id    = '0;
    if (op_add) begin
      wr.en   = finish;
      wr.fill = 1'b1;
      if (empty_found) begin
        wr_id = empty_id;
      end else if (old_found) begin
        wr_id = old_id;
      end
    end else if (exact_found) begin
      wr.en = finish;
      wr_id = exact_id;
    end else if (best_key != '0) begin
      wr.en = finish;
      wr_id = best_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      use_clock <= '0;
      out_valid <= 1'b0;
      out_hit   <= 1'b0;
      out_exact <= 1'b0;
      out_value <= '0;
    end else begin
      // a beat taken while the next one loads keeps valid high
      if (out_valid && rsp.ready && !finish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_add    <= (req.operation == OP_ADD);
            k_reg     <= req.key[LRUC_TKEY_W-1:0];
            val_reg   <= req.write_value;
            use_clock <= use_clock + 1'b1;
            state     <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            scan_base   <= mod_rem;
            cnt         <= '0;
            exact_found <= 1'b0;
            best_key    <= '0;
            empty_found <= 1'b0;
            old_found   <= 1'b0;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (take_exact) begin
            exact_found <= 1'b1;
            exact_id    <= head_id;
            exact_rank  <= head_rank;
            exact_data  <= head.data;
          end
          if (take_floor) begin
            best_key  <= head.tag.key;
            best_id   <= head_id;
            best_rank <= head_rank;
            best_data <= head.data;
          end
          if (take_empty) begin
            empty_found <= 1'b1;
            empty_id    <= head_id;
            empty_rank  <= head_rank;
          end
          if (take_old) begin
            old_found <= 1'b1;
            old_id    <= head_id;
            old_stamp <= head.stamp;
          end
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(ENTRIES - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (op_add) begin
              out_hit   <= 1'b0;
              out_exact <= 1'b0;
              out_value <= '0;
            end else if (exact_found) begin
              out_hit   <= 1'b1;
              out_exact <= 1'b1;
              out_value <= exact_data;
            end else if (best_key != '0) begin
              out_hit   <= 1'b1;
              out_exact <= 1'b0;
              out_value <= best_data;
            end else begin
              out_hit   <= 1'b0;
              out_exact <= 1'b0;
              out_value <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lruc_mod_unit.sv
// Remainder of a key byte by the entry count, by reciprocal multiplication.
module lruc_mod_unit import lruc_pkg::*; #(
  parameter int ENTRIES = LRUC_ENTRIES,
  parameter int IDX_W   = LRUC_IDX_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [LRUC_KEY_W-1:0] dividend,
  output logic                  done,
  output logic [IDX_W-1:0]      rem
);

  // floor(x * RECIP / 2^SHIFT) equals floor(x / ENTRIES) for every 8-bit x
  localparam int SHIFT  = 16;
  localparam int RECIP  = ((1 << SHIFT) + ENTRIES - 1) / ENTRIES;
  localparam int PROD_W = LRUC_KEY_W + SHIFT;

  logic [PROD_W-1:0]     prod;
  logic [LRUC_KEY_W-1:0] quot;
  logic [LRUC_KEY_W-1:0] back;
  logic [LRUC_KEY_W-1:0] diff;

  always_comb begin
    prod = PROD_W'(dividend) * PROD_W'(RECIP);
    quot = prod[SHIFT +: LRUC_KEY_W];
    back = quot * LRUC_KEY_W'(ENTRIES);
    diff = dividend - back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      rem  <= '0;
    end else begin
      done <= start;
      if (start) begin
        rem <= diff[IDX_W-1:0];
      end
    end
  end

endmodule

>>> sv/lruc_cell.sv
// Ring cell: one cache entry and its slot number, rotating toward cell 0.
module lruc_cell import lruc_pkg::*; #(
  parameter int IDX_W = LRUC_IDX_W
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [IDX_W-1:0] home_id,
  input  logic        shift,
  input  lruc_entry_t nbr_ent,
  input  logic [IDX_W-1:0] nbr_id,
  input  lruc_wr_t    wr,
  input  logic [IDX_W-1:0] wr_id,
  output lruc_entry_t ent,
  output logic [IDX_W-1:0] id
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
      id  <= home_id;
    end else if (shift) begin
      ent <= nbr_ent;
      id  <= nbr_id;
    end else if (wr.en && (wr_id == id)) begin
      ent.stamp <= wr.stamp;
      if (wr.fill) begin
        ent.tag  <= wr.tag;
        ent.data <= wr.data;
      end
    end
  end

endmodule

>>> sv/lruc_checker.sv
// Port-level checker for the LRU cache, bound to the top level.
`include "lru_cache_with_floor_fallback_defines.svh"

module lruc_port_props import lruc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_hit,
  input logic                  rsp_exact,
  input logic [LRUC_VAL_W-1:0] rsp_read_value
);

  // A stalled response beat holds its payload.
  `LRUC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_exact) && $stable(rsp_read_value))

  // Exact match is a kind of hit.
  `LRUC_ASSERT_IMP(a_exact_hit, rsp_valid && rsp_exact, rsp_hit)

  // Adds and misses return all-zero fields.
  `LRUC_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp_hit, !rsp_exact && (rsp_read_value == '0))

  // One request at a time: no beat is taken right after another.
  `LRUC_ASSERT_NXT(a_one_busy, req_valid && req_ready, !req_ready)

endmodule

bind lru_cache_with_floor_fallback lruc_port_props u_lruc_port_props (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .rsp_exact      (rsp.exact),
  .rsp_read_value (rsp.read_value)
);
